### src/ftri_pkg.sv
// Shared types and constants of the field-map trilinear interpolator.
// Used by the controller, the datapath and the interpolation lanes.
package ftri_pkg;

    localparam int IDX_W   = 8;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = IDX_W + FRAC_W;
    localparam int VAL_W   = 24;
    localparam int PT_W    = 32;
    localparam int SPAN_W  = 31;
    localparam int SCALE_W = 24;
    localparam int ACC_W   = VAL_W + FRAC_W;
    localparam int OUT_W   = 32;
    localparam int DIV_STEPS = Q_W;
    localparam int CFG_AW  = 3;

    localparam logic [CFG_AW-1:0] REG_LOW_X  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LOW_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LOW_Z  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SPAN_X = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SPAN_Y = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SPAN_Z = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SCALE  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] LS_Z = 2'd0;
    localparam logic [1:0] LS_Y = 2'd1;
    localparam logic [1:0] LS_X = 2'd2;

    typedef struct packed {
        logic       cap_in;
        logic       mem_we;
        logic       chk;
        logic       dload;
        logic       dstep;
        logic       dfinish;
        logic       rd;
        logic       rd_z;
        logic [1:0] lerp_sel;
        logic       cap_v0;
        logic       cap_by;
        logic       cap_bx;
        logic       cap_r;
        logic       sc;
        logic       out_load;
        logic [1:0] axis;
        logic [1:0] pair;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_box;
    } ctrl_stat_t;

endpackage

### src/ftri_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ftri_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/ftri_lerp.sv
// One-step linear blend a + floor((b - a) * f / 2^16); the result appears in the cycle after its inputs.
// Depends on ftri_pkg.
module ftri_lerp (
    input  logic                             aclk,
    input  logic signed [ftri_pkg::ACC_W-1:0] a,
    input  logic signed [ftri_pkg::ACC_W-1:0] b,
    input  logic [ftri_pkg::FRAC_W-1:0]       frac,
    output logic signed [ftri_pkg::ACC_W-1:0] res
);
    import ftri_pkg::*;

    logic signed [ACC_W:0]          diff;
    logic signed [ACC_W-FRAC_W:0]   diff_hi;
    logic signed [ACC_W-1:0]        base_reg;
    logic signed [ACC_W-FRAC_W+FRAC_W+1:0] hi_prod_reg;
    logic [2*FRAC_W-1:0]            lo_prod_reg;
    logic signed [ACC_W+FRAC_W+2:0] sum;

    assign diff    = {b[ACC_W-1], b} - {a[ACC_W-1], a};
    assign diff_hi = diff[ACC_W:FRAC_W];

    always_ff @(posedge aclk) begin
        base_reg    <= a;
        hi_prod_reg <= diff_hi * $signed({1'b0, frac});
        lo_prod_reg <= diff[FRAC_W-1:0] * frac;
    end

    assign sum = (ACC_W+FRAC_W+3)'(base_reg) + (ACC_W+FRAC_W+3)'(hi_prod_reg)
               + $signed({(ACC_W+3)'(0), lo_prod_reg[2*FRAC_W-1:FRAC_W]});
    assign res = sum[ACC_W-1:0];
endmodule

### src/ftri_dpath.sv
// Datapath: configuration registers, grid memories, span divider and three blend lanes.
// Depends on ftri_pkg, ftri_ram and ftri_lerp.
module ftri_dpath #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ftri_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [31:0]                    cfg_wdata,
    input  logic [183:0]                   s_tdata,
    input  logic                           s_tuser,
    input  ftri_pkg::ctrl_cmd_t            cmd,
    output ftri_pkg::ctrl_stat_t           stat,
    output logic [95:0]                    m_tdata,
    output logic                           m_tuser
);
    import ftri_pkg::*;

    localparam int NPTS = GRID_X * GRID_Y * GRID_Z;
    localparam int AW   = $clog2(NPTS);
    localparam logic [IDX_W-1:0] NM1_X = IDX_W'(GRID_X - 1);
    localparam logic [IDX_W-1:0] NM1_Y = IDX_W'(GRID_Y - 1);
    localparam logic [IDX_W-1:0] NM1_Z = IDX_W'(GRID_Z - 1);

    logic signed [PT_W-1:0]    low_x_reg, low_y_reg, low_z_reg;
    logic [SPAN_W-1:0]         span_x_reg, span_y_reg, span_z_reg;
    logic signed [SCALE_W-1:0] scale_reg;

    logic                      in_req_reg;
    logic [3:0]                in_cx_reg, in_cy_reg, in_cz_reg;
    logic [VAL_W-1:0]          in_val_reg [3];
    logic signed [PT_W-1:0]    in_px_reg, in_py_reg, in_pz_reg;

    logic                      inside_reg;
    logic [SPAN_W-1:0]         rem_reg;
    logic [Q_W-1:0]            nq_reg;
    logic [IDX_W-1:0]          ix_reg, iy_reg, iz_reg;
    logic [FRAC_W-1:0]         fx_reg, fy_reg, fz_reg;
    logic                      inside_out_reg;
    logic [OUT_W-1:0]          field_reg [3];

    function automatic logic axis_in(input logic signed [PT_W-1:0] p,
                                     input logic signed [PT_W-1:0] lo,
                                     input logic [SPAN_W-1:0] sp);
        logic signed [PT_W+1:0] p_e;
        logic signed [PT_W+1:0] lo_e;
        logic signed [PT_W+1:0] hi_e;
        p_e  = (PT_W+2)'(p);
        lo_e = (PT_W+2)'(lo);
        hi_e = lo_e + $signed({3'b000, sp});
        return (p_e > lo_e) && (p_e < hi_e);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W:0] x,
                                              input logic [IDX_W:0] y,
                                              input logic [IDX_W:0] z);
        return AW'((int'(x) * GRID_Y + int'(y)) * GRID_Z + int'(z));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            low_z_reg  <= '0;
            span_x_reg <= SPAN_W'(1);
            span_y_reg <= SPAN_W'(1);
            span_z_reg <= SPAN_W'(1);
            scale_reg  <= SCALE_W'(65536);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LOW_X:  low_x_reg  <= cfg_wdata;
                REG_LOW_Y:  low_y_reg  <= cfg_wdata;
                REG_LOW_Z:  low_z_reg  <= cfg_wdata;
                REG_SPAN_X: span_x_reg <= cfg_wdata[SPAN_W-1:0];
                REG_SPAN_Y: span_y_reg <= cfg_wdata[SPAN_W-1:0];
                REG_SPAN_Z: span_z_reg <= cfg_wdata[SPAN_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            in_req_reg <= s_tuser;
            in_cx_reg  <= s_tdata[3:0];
            in_cy_reg  <= s_tdata[7:4];
            in_cz_reg  <= s_tdata[11:8];
            for (int i = 0; i < 3; i++) begin
                in_val_reg[i] <= s_tdata[12 + VAL_W*i +: VAL_W];
            end
            in_px_reg  <= s_tdata[84 +: PT_W];
            in_py_reg  <= s_tdata[116 +: PT_W];
            in_pz_reg  <= s_tdata[148 +: PT_W];
        end
        if (cmd.chk) begin
            inside_reg <= axis_in(in_px_reg, low_x_reg, span_x_reg)
                        && axis_in(in_py_reg, low_y_reg, span_y_reg)
                        && axis_in(in_pz_reg, low_z_reg, span_z_reg);
        end
    end

    assign stat.is_query = in_req_reg;
    assign stat.in_box   = inside_reg;

    // Divider for (p - low) * (N - 1) * 2^16 / span, one quotient bit per cycle.
    logic signed [PT_W-1:0]       p_sel, lo_sel;
    logic [SPAN_W-1:0]            sp_sel;
    logic [IDX_W-1:0]             nm1_sel;
    logic signed [PT_W:0]         pt_off;
    logic [SPAN_W+IDX_W-1:0]      prod;
    logic [SPAN_W:0]              trial, trial_sub;
    logic                         ge;
    logic [Q_W-1:0]               q_new;
    logic [IDX_W-1:0]             idx_raw, idx_max, idx_c;

    always_comb begin
        case (cmd.axis)
            AXIS_X: begin
                p_sel = in_px_reg; lo_sel = low_x_reg; sp_sel = span_x_reg; nm1_sel = NM1_X;
            end
            AXIS_Y: begin
                p_sel = in_py_reg; lo_sel = low_y_reg; sp_sel = span_y_reg; nm1_sel = NM1_Y;
            end
            default: begin
                p_sel = in_pz_reg; lo_sel = low_z_reg; sp_sel = span_z_reg; nm1_sel = NM1_Z;
            end
        endcase
    end

    assign pt_off    = {p_sel[PT_W-1], p_sel} - {lo_sel[PT_W-1], lo_sel};
    assign prod      = pt_off[SPAN_W-1:0] * nm1_sel;
    assign trial     = {rem_reg, nq_reg[Q_W-1]};
    assign ge        = trial >= {1'b0, sp_sel};
    assign trial_sub = trial - {1'b0, sp_sel};
    assign q_new     = {nq_reg[Q_W-2:0], ge};
    assign idx_raw   = q_new[Q_W-1:FRAC_W];
    assign idx_max   = nm1_sel - IDX_W'(1);
    assign idx_c     = (idx_raw > idx_max) ? idx_max : idx_raw;

    always_ff @(posedge aclk) begin
        if (cmd.dload) begin
            rem_reg <= prod[SPAN_W+IDX_W-1:IDX_W];
            nq_reg  <= {prod[IDX_W-1:0], FRAC_W'(0)};
        end else if (cmd.dstep) begin
            rem_reg <= ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
            nq_reg  <= q_new;
        end
        if (cmd.dfinish) begin
            case (cmd.axis)
                AXIS_X: begin
                    ix_reg <= idx_c; fx_reg <= q_new[FRAC_W-1:0];
                end
                AXIS_Y: begin
                    iy_reg <= idx_c; fy_reg <= q_new[FRAC_W-1:0];
                end
                default: begin
                    iz_reg <= idx_c; fz_reg <= q_new[FRAC_W-1:0];
                end
            endcase
        end
    end

    // Grid addressing.
    logic            wr_ok;
    logic [AW-1:0]   waddr, raddr;
    logic [IDX_W:0]  cx, cy, cz;

    assign wr_ok = (int'(in_cx_reg) < GRID_X) && (int'(in_cy_reg) < GRID_Y)
                && (int'(in_cz_reg) < GRID_Z);
    assign waddr = addr_of((IDX_W+1)'(in_cx_reg), (IDX_W+1)'(in_cy_reg),
                           (IDX_W+1)'(in_cz_reg));
    assign cx    = {1'b0, ix_reg} + (IDX_W+1)'(cmd.pair[1]);
    assign cy    = {1'b0, iy_reg} + (IDX_W+1)'(cmd.pair[0]);
    assign cz    = {1'b0, iz_reg} + (IDX_W+1)'(cmd.rd_z);
    assign raddr = addr_of(cx, cy, cz);

    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
        logic [VAL_W-1:0]           rdata;
        logic [VAL_W-1:0]           v0_reg;
        logic signed [ACC_W-1:0]    by0_reg, by1_reg, bx0_reg, bx1_reg, r_reg;
        logic signed [ACC_W-1:0]    la, lb, lres;
        logic [FRAC_W-1:0]          lf;
        logic signed [2*SCALE_W-1:0] ph_reg;
        logic signed [SCALE_W+FRAC_W:0] pl_reg;
        logic signed [63:0]         sum;

        ftri_ram #(.WIDTH(VAL_W), .DEPTH(NPTS)) u_ram (
            .aclk  (aclk),
            .we    (cmd.mem_we && wr_ok),
            .waddr (waddr),
            .wdata (in_val_reg[ln]),
            .re    (cmd.rd),
            .raddr (raddr),
            .rdata (rdata)
        );

        always_comb begin
            case (cmd.lerp_sel)
                LS_Z: begin
                    la = {v0_reg, FRAC_W'(0)}; lb = {rdata, FRAC_W'(0)}; lf = fz_reg;
                end
                LS_Y: begin
                    la = by0_reg; lb = by1_reg; lf = fy_reg;
                end
                default: begin
                    la = bx0_reg; lb = bx1_reg; lf = fx_reg;
                end
            endcase
        end

        ftri_lerp u_lerp (
            .aclk (aclk),
            .a    (la),
            .b    (lb),
            .frac (lf),
            .res  (lres)
        );

        always_ff @(posedge aclk) begin
            if (cmd.cap_v0) begin
                v0_reg <= rdata;
            end
            if (cmd.cap_by) begin
                if (cmd.pair[0]) begin
                    by1_reg <= lres;
                end else begin
                    by0_reg <= lres;
                end
            end
            if (cmd.cap_bx) begin
                if (cmd.pair[1]) begin
                    bx1_reg <= lres;
                end else begin
                    bx0_reg <= lres;
                end
            end
            if (cmd.cap_r) begin
                r_reg <= lres;
            end
            if (cmd.sc) begin
                ph_reg <= $signed(r_reg[ACC_W-1:FRAC_W]) * scale_reg;
                pl_reg <= $signed({1'b0, r_reg[FRAC_W-1:0]}) * scale_reg;
            end
            if (cmd.out_load) begin
                field_reg[ln] <= inside_reg ? sum[63:32] : OUT_W'(0);
            end
        end

        assign sum = $signed({ph_reg, FRAC_W'(0)}) + 64'(pl_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            inside_out_reg <= inside_reg;
        end
    end

    assign m_tdata = {field_reg[2], field_reg[1], field_reg[0]};
    assign m_tuser = inside_out_reg;
endmodule

### src/ftri_ctrl.sv
// Controller state machine: sequences writes, span divisions, corner reads and blends.
// Depends on ftri_pkg.
module ftri_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ftri_pkg::ctrl_stat_t stat,
    output ftri_pkg::ctrl_cmd_t  cmd
);
    import ftri_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_DLOAD = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RA    = 4'd4;
    localparam logic [3:0] S_RB    = 4'd5;
    localparam logic [3:0] S_LZ    = 4'd6;
    localparam logic [3:0] S_CZ    = 4'd7;
    localparam logic [3:0] S_LY    = 4'd8;
    localparam logic [3:0] S_CY    = 4'd9;
    localparam logic [3:0] S_LX    = 4'd10;
    localparam logic [3:0] S_CX    = 4'd11;
    localparam logic [3:0] S_SC    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] pair_reg, pair_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            axis_reg     <= AXIS_X;
            pair_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            axis_reg     <= axis_next;
            pair_reg     <= pair_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        pair_next  = pair_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.pair   = pair_reg;
        cmd.lerp_sel = LS_Z;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (stat.is_query) begin
                    cmd.chk    = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = S_DLOAD;
                end else begin
                    cmd.mem_we = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DLOAD: begin
                if (stat.in_box) begin
                    cmd.dload  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                cmd.dstep = 1'b1;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    cmd.dfinish = 1'b1;
                    if (axis_reg == AXIS_Z) begin
                        pair_next  = '0;
                        state_next = S_RA;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_DLOAD;
                    end
                end
            end
            S_RA: begin
                cmd.rd     = 1'b1;
                state_next = S_RB;
            end
            S_RB: begin
                cmd.rd     = 1'b1;
                cmd.rd_z   = 1'b1;
                cmd.cap_v0 = 1'b1;
                state_next = S_LZ;
            end
            S_LZ: begin
                cmd.lerp_sel = LS_Z;
                state_next   = S_CZ;
            end
            S_CZ: begin
                cmd.cap_by = 1'b1;
                if (pair_reg[0]) begin
                    state_next = S_LY;
                end else begin
                    pair_next  = pair_reg + 2'd1;
                    state_next = S_RA;
                end
            end
            S_LY: begin
                cmd.lerp_sel = LS_Y;
                state_next   = S_CY;
            end
            S_CY: begin
                cmd.cap_bx = 1'b1;
                if (pair_reg[1]) begin
                    state_next = S_LX;
                end else begin
                    pair_next  = pair_reg + 2'd1;
                    state_next = S_RA;
                end
            end
            S_LX: begin
                cmd.lerp_sel = LS_X;
                state_next   = S_CX;
            end
            S_CX: begin
                cmd.cap_r  = 1'b1;
                state_next = S_SC;
            end
            S_SC: begin
                cmd.sc     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && m_tvalid_next) |-> (state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV || state_reg == S_DLOAD) |-> (axis_reg != 2'd3))
        else $error("divider axis out of range");

    a_write_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_we |-> !stat.is_query)
        else $error("grid written by a query item");
endmodule

### src/field_map_trilinear_interpolator.sv
// Top level of the field-map trilinear interpolator: controller plus datapath.
// Depends on ftri_pkg, ftri_ctrl and ftri_dpath.
//
// Channel   Direction  Handshake          Payload
// s_        in         tvalid/tready      tdata query or write fields, tuser req_type
// m_        out        tvalid/tready      tdata field_x/y/z, tuser inside_res
// cfg_      in         cfg_wr_en          cfg_addr register index, cfg_wdata value
//
// A write item passes the decode state back to idle; a query outside the box goes
// from the box check to the done state. A query inside the box runs three 24-step
// span divisions on one shared divider, then eight corner reads and seven blends.
// Reset is synchronous and active low; the grid memories are not cleared.
// A finished result waits in the output register; the block returns to accept
// the next item, and a later result waits in the done state while m_tready is low.
module field_map_trilinear_interpolator #(
    parameter int GRID_X = 16,
    parameter int GRID_Y = 16,
    parameter int GRID_Z = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ftri_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]                 cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // cell_x, cell_y, cell_z, value_x, value_y, value_z, point_x, point_y, point_z, pad
    input  logic [183:0]                s_tdata,
    // req_type
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // field_x, field_y, field_z
    output logic [95:0]                 m_tdata,
    // inside_res
    output logic                        m_tuser
);
    import ftri_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    ftri_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ftri_dpath #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

### dv/ftri_checker.sv
`timescale 1ns / 100ps
// Checker of the field-map trilinear interpolator: watches the config port and both
// item channels, predicts every result and compares it. Depends on ftri_pkg.
module ftri_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ftri_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]                 cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [183:0]                s_tdata,
    input  logic                        s_tuser,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [95:0]                 m_tdata,
    input  logic                        m_tuser,
    output int                          fail_count,
    output int                          pending
);
    import ftri_pkg::*;

    localparam int GN = 16;

    typedef struct packed {
        logic               in_box;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
    } field_res_t;

    field_res_t field_q[$];

    logic signed [31:0] lo_r [3];
    logic [30:0]        span_r [3];
    logic signed [23:0] scale_r;
    logic signed [23:0] grid_v [3][GN*GN*GN];

    assign pending = field_q.size();

    function automatic bit locate(input longint p, input longint lo, input longint span,
                                  output int idx, output longint frac);
        longint unsigned t;
        if (!(p > lo && p < lo + span) || span == 0) return 0;
        t = (longint'(p - lo) * (GN - 1) * 65536) / span;
        idx = int'(t >> 16);
        frac = longint'(t & 64'hFFFF);
        if (idx > GN - 2) idx = GN - 2;
        return 1;
    endfunction

    function automatic logic signed [31:0] blend_comp(input int c, input int ix, input int iy,
                                                      input int iz, input longint fx,
                                                      input longint fy, input longint fz);
        longint by [2];
        longint bx [2];
        longint r;
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                by[b] = longint'(grid_v[c][((ix + a) * GN + iy + b) * GN + iz]) * (65536 - fz)
                      + longint'(grid_v[c][((ix + a) * GN + iy + b) * GN + iz + 1]) * fz;
            end
            bx[a] = (by[0] * (65536 - fy) + by[1] * fy) >>> 16;
        end
        r = (bx[0] * (65536 - fx) + bx[1] * fx) >>> 16;
        r = (r * longint'(scale_r)) >>> 32;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic field_res_t predict_field(input logic [183:0] d);
        field_res_t res;
        int ix, iy, iz;
        longint fx, fy, fz;
        res = '0;
        if (locate(longint'($signed(d[115:84])), lo_r[0], span_r[0], ix, fx) &&
            locate(longint'($signed(d[147:116])), lo_r[1], span_r[1], iy, fy) &&
            locate(longint'($signed(d[179:148])), lo_r[2], span_r[2], iz, fz)) begin
            res.in_box = 1'b1;
            res.fx = blend_comp(0, ix, iy, iz, fx, fy, fz);
            res.fy = blend_comp(1, ix, iy, iz, fx, fy, fz);
            res.fz = blend_comp(2, ix, iy, iz, fx, fy, fz);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        field_res_t want;
        int a;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
            field_q.delete();
            lo_r = '{0, 0, 0};
            span_r = '{31'd1, 31'd1, 31'd1};
            scale_r = 24'sd65536;
        end else begin
            if (m_tvalid && m_tready) begin
                if (field_q.size() == 0) begin
                    $error("unexpected result item inside_res=%0d", m_tuser);
                    errs++;
                end else begin
                    want = field_q.pop_front();
                    if (m_tuser !== want.in_box) begin
                        $error("inside_res expected %0d actual %0d", want.in_box, m_tuser);
                        errs++;
                    end
                    if (m_tdata[31:0] !== want.fx) begin
                        $error("field_x expected %0d actual %0d", want.fx,
                               $signed(m_tdata[31:0]));
                        errs++;
                    end
                    if (m_tdata[63:32] !== want.fy) begin
                        $error("field_y expected %0d actual %0d", want.fy,
                               $signed(m_tdata[63:32]));
                        errs++;
                    end
                    if (m_tdata[95:64] !== want.fz) begin
                        $error("field_z expected %0d actual %0d", want.fz,
                               $signed(m_tdata[95:64]));
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    field_q.push_back(predict_field(s_tdata));
                end else begin
                    a = (int'(s_tdata[3:0]) * GN + int'(s_tdata[7:4])) * GN
                        + int'(s_tdata[11:8]);
                    grid_v[0][a] = s_tdata[35:12];
                    grid_v[1][a] = s_tdata[59:36];
                    grid_v[2][a] = s_tdata[83:60];
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LOW_X:  lo_r[0] = cfg_wdata;
                    REG_LOW_Y:  lo_r[1] = cfg_wdata;
                    REG_LOW_Z:  lo_r[2] = cfg_wdata;
                    REG_SPAN_X: span_r[0] = cfg_wdata[30:0];
                    REG_SPAN_Y: span_r[1] = cfg_wdata[30:0];
                    REG_SPAN_Z: span_r[2] = cfg_wdata[30:0];
                    REG_SCALE:  scale_r = cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (errs != 0) begin
                fail_count <= fail_count + errs;
            end
        end
    end
endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Top of the interpolator testbench: clock, reset, config phases and item stimulus.
// Depends on ftri_pkg, field_map_trilinear_interpolator and ftri_checker.
module tb;
    import ftri_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int     GN = 16;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [31:0]         cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [183:0]        s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [95:0]         m_tdata;
    logic                m_tuser;
    int                  fail_count;
    int                  pending;
    longint              cycles = 0;
    bit                  busy_mode = 0;

    longint lo_c [3] = '{0, 0, 0};
    longint span_c [3] = '{1, 1, 1};

    always #1 aclk = ~aclk;

    field_map_trilinear_interpolator u_top (.*);
    ftri_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("field_map_trilinear_interpolator test failed");
            $finish;
        end
    end

    initial begin
        int n;
        @(negedge aclk);
        forever begin
            n = busy_mode ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Only grid indices in three slabs per axis are written at the start, and
    // queries are steered to cells whose eight corners all lie in those slabs.
    function automatic bit in_fill(input int k);
        return (k <= 2) || (k >= 6 && k <= 8) || (k >= 13);
    endfunction

    function automatic bit cell_ok(input longint idx);
        return (idx <= 1) || (idx == 6) || (idx == 7) || (idx >= 13);
    endfunction

    task automatic send_item(input logic req, input logic [183:0] d, input bit no_gap);
        int gap;
        gap = (no_gap || busy_mode) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= d;
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_cell(input int cx, input int cy, input int cz, input logic [23:0] vx,
                              input logic [23:0] vy, input logic [23:0] vz, input bit no_gap);
        logic [183:0] d;
        d = '0;
        d[3:0] = 4'(cx);
        d[7:4] = 4'(cy);
        d[11:8] = 4'(cz);
        d[35:12] = vx;
        d[59:36] = vy;
        d[83:60] = vz;
        send_item(1'b0, d, no_gap);
    endtask

    task automatic query_point(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] pz);
        logic [183:0] d;
        d = 184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        d[115:84] = px;
        d[147:116] = py;
        d[179:148] = pz;
        d[183:180] = '0;
        send_item(1'b1, d, 1'b0);
    endtask

    function automatic logic [31:0] pick_coord(input int ax);
        longint lo, sp, p, t;
        bit ok;
        lo = lo_c[ax];
        sp = span_c[ax];
        p = lo;
        ok = 1'b0;
        while (!ok) begin
            case ($urandom_range(0, 19))
                0: p = lo;
                1: p = lo + sp;
                2: p = lo + 1;
                3: p = lo + sp - 1;
                4: p = longint'($signed($urandom));
                default: p = lo + 1 + longint'({$urandom, $urandom} % (sp > 1 ? sp - 1 : 1));
            endcase
            p = longint'($signed(p[31:0]));
            ok = 1'b1;
            if (p > lo && p < lo + sp) begin
                t = ((p - lo) * (GN - 1) * 65536) / sp;
                ok = cell_ok(t >> 16);
            end
        end
        return p[31:0];
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input longint lx, input longint ly, input longint lz,
                              input longint sx, input longint sy, input longint sz,
                              input logic [23:0] sc);
        lo_c = '{lx, ly, lz};
        span_c = '{sx, sy, sz};
        write_reg(REG_LOW_X, lx[31:0]);
        write_reg(REG_LOW_Y, ly[31:0]);
        write_reg(REG_LOW_Z, lz[31:0]);
        write_reg(REG_SPAN_X, {1'b0, sx[30:0]});
        write_reg(REG_SPAN_Y, {1'b0, sy[30:0]});
        write_reg(REG_SPAN_Z, {1'b0, sz[30:0]});
        write_reg(REG_SCALE, {8'h00, sc});
        write_reg(REG_UNUSED, $urandom);
        lo_c[0] = $signed(lx[31:0]);
        lo_c[1] = $signed(ly[31:0]);
        lo_c[2] = $signed(lz[31:0]);
    endtask

    initial begin
        longint sp;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int x = 0; x < GN; x++)
            for (int y = 0; y < GN; y++)
                for (int z = 0; z < GN; z++)
                    if (in_fill(x) && in_fill(y) && in_fill(z))
                        write_cell(x, y, z, 24'($urandom), 24'($urandom), 24'($urandom),
                                   1'b1);

        query_point(0, 0, 0);
        query_point(1, 1, 1);
        query_point(32'hFFFF_FFFF, 0, 1);
        wait_drained();

        set_config(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'h7F_FFFF);
        write_cell(0, 0, 0, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 1'b0);
        write_cell(0, 0, 1, 24'h80_0000, 24'h7F_FFFF, 24'h00_0000, 1'b0);
        write_cell(15, 15, 15, 24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 1'b0);
        write_cell(14, 14, 14, 24'h80_0000, 24'h80_0000, 24'h7F_FFFF, 1'b0);
        query_point(32'h8000_0001, 32'h8000_0001, 32'h8000_0001);
        query_point(32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFE);
        query_point(32'h7FFF_FFFF, 32'h0, 32'h0);
        query_point(32'h8000_0000, 32'h0, 32'h0);
        query_point(32'h0, 32'h0, 32'h0);
        wait_drained();

        set_config(0, 0, 0, 2, 2, 2, 24'h80_0000);
        query_point(1, 1, 1);
        query_point(2, 1, 1);
        query_point(1, 1, 0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            busy_mode = (ph == 2);
            case (ph)
                0: set_config(0, 0, 0, 1, 1, 1, 24'h01_0000);
                1: set_config(-64'sd2147483648, 0, 64'sd1000, 31'h7FFF_FFFF, 31'd1000,
                              31'd15 << 16, 24'h80_0000);
                2: set_config($signed($urandom), $signed($urandom), $signed($urandom),
                              $urandom_range(1, 32'h7FFF_FFFF), $urandom_range(2, 1 << 20),
                              $urandom_range(2, 1 << 24), 24'h7F_FFFF);
                default: begin
                    sp = $urandom_range(2, 1 << ($urandom_range(2, 30)));
                    set_config($signed($urandom), $signed($urandom), $signed($urandom),
                               sp, $urandom_range(2, 32'h7FFF_FFFF),
                               $urandom_range(16, 1 << 22), 24'($urandom));
                end
            endcase
            for (int i = 0; i < 150; i++) begin
                if ($urandom_range(0, 9) < 3)
                    write_cell($urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), 24'($urandom), 24'($urandom),
                               24'($urandom), 1'b0);
                else
                    query_point(pick_coord(0), pick_coord(1), pick_coord(2));
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("field_map_trilinear_interpolator test passed");
        end else begin
            $display("field_map_trilinear_interpolator test failed");
        end
        $finish;
    end
endmodule
